[rtl/stct_pkg.sv]
// ----------------------------------------------------------------------------
// stct_pkg
// Shared types and constants of the scene transfer completion tracker.
// ----------------------------------------------------------------------------
package stct_pkg;

	localparam int MAX_OBJECTS    = 64;
	localparam int IDS_PER_PACKET = 32;
	localparam int ADDR_W         = $clog2(MAX_OBJECTS);
	localparam int CNT_W          = $clog2(MAX_OBJECTS + 1);

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_OBJECT = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;

	typedef enum logic [1:0] {
		KIND_READY    = 2'd0,
		KIND_ASK      = 2'd1,
		KIND_DONE     = 2'd2,
		KIND_MISMATCH = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_OBJ,
		ST_CNT,
		ST_DECIDE,
		ST_ASK_RD,
		ST_ASK_EV
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] token;
		logic [6:0]  total_count;
		logic [5:0]  object_id;
		logic [31:0] server_checksum;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] echo_token;
		logic [5:0]  missing_id;
		logic [6:0]  batch_size;
		logic        batch_end;
		logic        run_end;
	} result_t;

endpackage

[rtl/stct_if.sv]
// ----------------------------------------------------------------------------
// stct_item_if / stct_result_if
// Valid/ready item and result channels of the completion tracker.
// ----------------------------------------------------------------------------
interface stct_item_if;
	logic              valid;
	logic              ready;
	stct_pkg::item_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface stct_result_if;
	logic              valid;
	logic              ready;
	stct_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/scene_transfer_completion_tracker.sv]
// ----------------------------------------------------------------------------
// scene_transfer_completion_tracker
// Receiver-side tracker of a token-tagged transfer: marks arrived object ids
// in a received map, asks for missing ids in batches, checks the id checksum.
//
// Channels: item (sink) takes start, object and end requests; result (source)
// gives ready replies, asks, completion and mismatch status, run_end marking
// the last result of one request. cfg_we/cfg_wdata set sink_q.
// One request is handled at a time; the received map is a 64 x 1 synchronous
// RAM, so each map read returns its data registered.
// Start: a ready reply is loaded into the output register; a new transfer then
// runs a clearing pass of the map before the next request is taken.
// Object: read, modify, write back, then the finalize check if end seen and sink_q set.
// Finalize: a count pass over the expected ids, then either one status
// result or an ask pass that reads each scanned id, up to 64 asks.
// After reset the block runs the same clearing pass, item.ready low.
// A stalled result holds in the output register; the next request is still
// taken, and the block waits only when it needs the output register again.
// ----------------------------------------------------------------------------
module scene_transfer_completion_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	stct_item_if.sink            item,
	stct_result_if.source        result
);
	import stct_pkg::*;

	state_t              st_q, st_d;
	logic [ADDR_W-1:0]   clr_q, clr_d;
	item_t               req_q, req_d;
	logic [31:0]         token_q, token_d;
	logic [CNT_W-1:0]    exp_count_q, exp_count_d;
	logic [31:0]         exp_sum_q, exp_sum_d;
	logic                end_seen_q, end_seen_d;
	logic                done_q, done_d;
	logic [15:0]         id_xor_q, id_xor_d;
	logic                sink_q;
	logic [CNT_W-1:0]    scan_q, scan_d;
	logic                chk_s1, chk_d;
	logic [CNT_W-1:0]    miss_q, miss_d;
	logic [CNT_W-1:0]    remain_q, remain_d;
	logic [CNT_W-1:0]    pos_q, pos_d;
	logic [CNT_W-1:0]    bs_q, bs_d;
	logic                out_valid_q;
	result_t             out_q, out_d;
	logic                out_load;
	logic                out_free;

	logic                mem [MAX_OBJECTS];
	logic                rdata_s1;
	logic                mem_we, mem_wdata, mem_re;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;

	logic                repeat_start;
	logic                foreign;
	logic [CNT_W-1:0]    count_sat;
	logic [CNT_W-1:0]    bs_cur;
	logic                batch_last;

	assign out_free     = !out_valid_q || result.ready;
	assign repeat_start = (token_q != 32'd0) && (req_q.token == token_q);
	assign foreign      = done_q || (req_q.token != token_q);
	assign count_sat    = (req_q.total_count > CNT_W'(MAX_OBJECTS)) ?
		CNT_W'(MAX_OBJECTS) : req_q.total_count;
	assign bs_cur       = (pos_q != '0) ? bs_q :
		((remain_q > CNT_W'(IDS_PER_PACKET)) ? CNT_W'(IDS_PER_PACKET) : remain_q);
	assign batch_last   = (pos_q + CNT_W'(1)) == bs_cur;

	assign item.ready   = (st_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	always_comb begin
		st_d        = st_q;
		clr_d       = clr_q;
		req_d       = req_q;
		token_d     = token_q;
		exp_count_d = exp_count_q;
		exp_sum_d   = exp_sum_q;
		end_seen_d  = end_seen_q;
		done_d      = done_q;
		id_xor_d    = id_xor_q;
		scan_d      = scan_q;
		chk_d       = 1'b0;
		miss_d      = miss_q;
		remain_d    = remain_q;
		pos_d       = pos_q;
		bs_d        = bs_q;
		mem_we      = 1'b0;
		mem_waddr   = clr_q;
		mem_wdata   = 1'b0;
		mem_re      = 1'b0;
		mem_raddr   = req_q.object_id;
		out_load    = 1'b0;
		out_d.kind       = KIND_READY;
		out_d.echo_token = token_q;
		out_d.missing_id = '0;
		out_d.batch_size = '0;
		out_d.batch_end  = 1'b0;
		out_d.run_end    = 1'b1;

		case (st_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				clr_d  = clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(MAX_OBJECTS - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item.valid) begin
					req_d = item.data;
					st_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (req_q.op)
					OP_START: begin
						if (out_free) begin
							out_load = 1'b1;
							if (repeat_start) begin
								st_d = ST_IDLE;
							end else begin
								token_d          = req_q.token;
								out_d.echo_token = req_q.token;
								exp_count_d      = count_sat;
								exp_sum_d        = '0;
								end_seen_d       = 1'b0;
								done_d           = 1'b0;
								id_xor_d         = '0;
								clr_d            = '0;
								st_d             = ST_CLEAR;
							end
						end
					end
					OP_OBJECT: begin
						if (foreign) begin
							st_d = ST_IDLE;
						end else begin
							mem_re = 1'b1;
							st_d   = ST_OBJ;
						end
					end
					OP_END: begin
						if (foreign) begin
							st_d = ST_IDLE;
						end else begin
							exp_sum_d  = req_q.server_checksum;
							end_seen_d = 1'b1;
							scan_d     = '0;
							miss_d     = '0;
							st_d       = ST_CNT;
						end
					end
					default: begin
						st_d = ST_IDLE;
					end
				endcase
			end
			ST_OBJ: begin
				if (({1'b0, req_q.object_id} < CNT_W'(MAX_OBJECTS)) && !rdata_s1) begin
					mem_we    = 1'b1;
					mem_waddr = req_q.object_id;
					mem_wdata = 1'b1;
					id_xor_d  = id_xor_q ^ {10'd0, req_q.object_id};
				end
				if (end_seen_q && sink_q) begin
					scan_d = '0;
					miss_d = '0;
					st_d   = ST_CNT;
				end else begin
					st_d = ST_IDLE;
				end
			end
			ST_CNT: begin
				mem_raddr = scan_q[ADDR_W-1:0];
				if (scan_q < exp_count_q) begin
					mem_re = 1'b1;
					chk_d  = 1'b1;
					scan_d = scan_q + CNT_W'(1);
				end
				if (chk_s1 && !rdata_s1) begin
					miss_d = miss_q + CNT_W'(1);
				end
				if (!(scan_q < exp_count_q) && !chk_s1) begin
					st_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (miss_q != '0) begin
					remain_d = miss_q;
					pos_d    = '0;
					scan_d   = '0;
					st_d     = ST_ASK_RD;
				end else if (out_free) begin
					out_load = 1'b1;
					if (id_xor_q == exp_sum_q[15:0] && exp_sum_q[31:16] == 16'd0) begin
						out_d.kind = KIND_DONE;
						done_d     = 1'b1;
					end else begin
						out_d.kind = KIND_MISMATCH;
					end
					st_d = ST_IDLE;
				end
			end
			ST_ASK_RD: begin
				mem_re    = 1'b1;
				mem_raddr = scan_q[ADDR_W-1:0];
				st_d      = ST_ASK_EV;
			end
			ST_ASK_EV: begin
				if (rdata_s1) begin
					scan_d = scan_q + CNT_W'(1);
					st_d   = ST_ASK_RD;
				end else if (out_free) begin
					out_load         = 1'b1;
					out_d.kind       = KIND_ASK;
					out_d.missing_id = scan_q[ADDR_W-1:0];
					out_d.batch_size = bs_cur;
					out_d.batch_end  = batch_last;
					out_d.run_end    = (remain_q == CNT_W'(1));
					bs_d             = bs_cur;
					pos_d            = batch_last ? '0 : pos_q + CNT_W'(1);
					remain_d         = remain_q - CNT_W'(1);
					scan_d           = scan_q + CNT_W'(1);
					st_d             = (remain_q == CNT_W'(1)) ? ST_IDLE : ST_ASK_RD;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			token_q     <= '0;
			exp_count_q <= '0;
			exp_sum_q   <= '0;
			end_seen_q  <= 1'b0;
			done_q      <= 1'b0;
			id_xor_q    <= '0;
			sink_q      <= 1'b0;
			scan_q      <= '0;
			chk_s1      <= 1'b0;
			miss_q      <= '0;
			remain_q    <= '0;
			pos_q       <= '0;
			bs_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			clr_q       <= clr_d;
			token_q     <= token_d;
			exp_count_q <= exp_count_d;
			exp_sum_q   <= exp_sum_d;
			end_seen_q  <= end_seen_d;
			done_q      <= done_d;
			id_xor_q    <= id_xor_d;
			scan_q      <= scan_d;
			chk_s1      <= chk_d;
			miss_q      <= miss_d;
			remain_q    <= remain_d;
			pos_q       <= pos_d;
			bs_q        <= bs_d;
			if (cfg_we) begin
				sink_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold request and result payloads
	always_ff @(posedge clk) begin
		req_q <= req_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// received map
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_raddr];
		end
	end

	a_ask_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_ASK) |->
		({1'b0, out_q.missing_id} < exp_count_q))
		else $error("ask for id beyond expected count");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CNT || st_q == ST_ASK_RD || st_q == ST_ASK_EV) |-> !mem_we)
		else $error("map written during scan");

	a_ask_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ASK_EV) |-> (remain_q != '0))
		else $error("ask pass with no missing id left");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> (out_valid_q && out_q.kind == KIND_DONE && out_q.run_end))
		else $error("completion without completion result");

endmodule
